@@ sv/aimd_pkg.sv @@
// ---------------------------------------------------------------------------
// AIMD rate and tier control: shared definitions
// Types, register indexes, tier codes and reset values used across the block.
// ---------------------------------------------------------------------------
package aimd_pkg;

	localparam int PACKET_BYTES = 1400;

	localparam int RATE_W    = 16;
	localparam int STEP_W    = 10;
	localparam int LOSS_W    = 14;
	localparam int BITRATE_W = 27;
	localparam int TIER_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 27;
	// 3 * bitrate and 11 * bitrate thresholds
	localparam int UP_THR_W  = BITRATE_W + 2;
	localparam int DN_THR_W  = BITRATE_W + 4;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_FLOOR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_CEILING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_THRESH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_BITRATE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MID_BITRATE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_BITRATE = 3'd6;

	localparam logic [TIER_W-1:0] TIER_LOW  = 2'd0;
	localparam logic [TIER_W-1:0] TIER_MID  = 2'd1;
	localparam logic [TIER_W-1:0] TIER_HIGH = 2'd2;

	localparam logic [0:0] OP_LOSS    = 1'b0;
	localparam logic [0:0] OP_SEGMENT = 1'b1;

	localparam logic [RATE_W-1:0]    RESET_RATE         = 16'd500;
	localparam logic [STEP_W-1:0]    RESET_RATE_STEP    = 10'd10;
	localparam logic [RATE_W-1:0]    RESET_RATE_FLOOR   = 16'd10;
	localparam logic [RATE_W-1:0]    RESET_RATE_CEILING = 16'd5000;
	localparam logic [LOSS_W-1:0]    RESET_LOSS_THRESH  = 14'd500;
	localparam logic [BITRATE_W-1:0] RESET_MID_BITRATE  = 27'd1200000;
	localparam logic [BITRATE_W-1:0] RESET_HIGH_BITRATE = 27'd2500000;

	// Configuration as seen by the datapath; bitrates are held pre-scaled.
	typedef struct packed {
		logic [STEP_W-1:0]   rate_step;
		logic [RATE_W-1:0]   rate_floor;
		logic [RATE_W-1:0]   rate_ceiling;
		logic [LOSS_W-1:0]   loss_threshold;
		logic [UP_THR_W-1:0] up_mid;
		logic [UP_THR_W-1:0] up_high;
		logic [DN_THR_W-1:0] dn_mid;
		logic [DN_THR_W-1:0] dn_high;
	} cfg_t;

	typedef struct packed {
		logic [RATE_W-1:0] packet_rate;
		logic [TIER_W-1:0] quality_tier;
		logic              tier_changed;
		logic              rate_dropped;
	} result_t;

endpackage

@@ sv/aimd_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// AIMD configuration registers
// Holds the control registers and scales the mid and high tier bitrates as written.
// ---------------------------------------------------------------------------
module aimd_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [aimd_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [aimd_pkg::CFG_DAT_W-1:0]   cfg_wdata,
	output aimd_pkg::cfg_t                   cfg
);

	aimd_pkg::cfg_t cfg_q;
	logic [aimd_pkg::BITRATE_W-1:0] br;
	logic [aimd_pkg::UP_THR_W-1:0]  br_x3;
	logic [aimd_pkg::DN_THR_W-1:0]  br_x11;

	assign br     = cfg_wdata[aimd_pkg::BITRATE_W-1:0];
	assign br_x3  = aimd_pkg::UP_THR_W'({br, 1'b0}) + aimd_pkg::UP_THR_W'(br);
	assign br_x11 = aimd_pkg::DN_THR_W'({br, 3'b000}) + aimd_pkg::DN_THR_W'({br, 1'b0})
		+ aimd_pkg::DN_THR_W'(br);

	// The low tier bitrate never enters a comparison, so its writes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_step      <= aimd_pkg::RESET_RATE_STEP;
			cfg_q.rate_floor     <= aimd_pkg::RESET_RATE_FLOOR;
			cfg_q.rate_ceiling   <= aimd_pkg::RESET_RATE_CEILING;
			cfg_q.loss_threshold <= aimd_pkg::RESET_LOSS_THRESH;
			cfg_q.up_mid         <= aimd_pkg::UP_THR_W'(aimd_pkg::RESET_MID_BITRATE * 3);
			cfg_q.up_high        <= aimd_pkg::UP_THR_W'(aimd_pkg::RESET_HIGH_BITRATE * 3);
			cfg_q.dn_mid         <= aimd_pkg::DN_THR_W'(aimd_pkg::RESET_MID_BITRATE * 11);
			cfg_q.dn_high        <= aimd_pkg::DN_THR_W'(aimd_pkg::RESET_HIGH_BITRATE * 11);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				aimd_pkg::REG_RATE_STEP:    cfg_q.rate_step <= cfg_wdata[aimd_pkg::STEP_W-1:0];
				aimd_pkg::REG_RATE_FLOOR:
					cfg_q.rate_floor <= cfg_wdata[aimd_pkg::RATE_W-1:0];
				aimd_pkg::REG_RATE_CEILING:
					cfg_q.rate_ceiling <= cfg_wdata[aimd_pkg::RATE_W-1:0];
				aimd_pkg::REG_LOSS_THRESH:
					cfg_q.loss_threshold <= cfg_wdata[aimd_pkg::LOSS_W-1:0];
				aimd_pkg::REG_MID_BITRATE: begin
					cfg_q.up_mid <= br_x3;
					cfg_q.dn_mid <= br_x11;
				end
				aimd_pkg::REG_HIGH_BITRATE: begin
					cfg_q.up_high <= br_x3;
					cfg_q.dn_high <= br_x11;
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/aimd_core.sv @@
// ---------------------------------------------------------------------------
// AIMD update core
// Holds the packet rate and tier, and applies one event per enabled cycle.
// ---------------------------------------------------------------------------
module aimd_core #(
	parameter int PACKET_BYTES = aimd_pkg::PACKET_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic                          op,
	input  logic [aimd_pkg::LOSS_W-1:0]   loss_level,
	input  aimd_pkg::cfg_t                cfg,
	output aimd_pkg::result_t             res
);

	localparam int K2      = PACKET_BYTES * 16;
	localparam int K10     = PACKET_BYTES * 80;
	localparam int EST10_W = aimd_pkg::RATE_W + $clog2(K10 + 1);
	localparam int CMP_W   = (EST10_W > aimd_pkg::DN_THR_W) ? EST10_W : aimd_pkg::DN_THR_W;
	localparam logic [CMP_W-1:0] K2_C  = CMP_W'(K2);
	localparam logic [CMP_W-1:0] K10_C = CMP_W'(K10);

	logic [aimd_pkg::RATE_W-1:0] rate_q;
	logic [aimd_pkg::TIER_W-1:0] tier_q;

	logic [aimd_pkg::RATE_W-1:0] half_rate;
	logic [aimd_pkg::RATE_W:0]   sum_rate;
	logic [aimd_pkg::RATE_W-1:0] rate_nxt;
	logic [aimd_pkg::TIER_W-1:0] tier_nxt;
	logic                        dropped;
	logic [CMP_W-1:0]            est_x2;
	logic [CMP_W-1:0]            est_x10;
	logic                        up_ok;
	logic                        dn_ok;

	assign half_rate = rate_q >> 1;
	assign sum_rate  = {1'b0, rate_q} + (aimd_pkg::RATE_W + 1)'(cfg.rate_step);
	assign est_x2    = CMP_W'(rate_q) * K2_C;
	assign est_x10   = CMP_W'(rate_q) * K10_C;

	always_comb begin
		up_ok = 1'b0;
		dn_ok = 1'b0;
		unique case (tier_q)
			aimd_pkg::TIER_LOW:  up_ok = est_x2 > CMP_W'(cfg.up_mid);
			aimd_pkg::TIER_MID: begin
				up_ok = est_x2 > CMP_W'(cfg.up_high);
				dn_ok = est_x10 < CMP_W'(cfg.dn_mid);
			end
			aimd_pkg::TIER_HIGH: dn_ok = est_x10 < CMP_W'(cfg.dn_high);
			default: ;
		endcase
	end

	always_comb begin
		rate_nxt = rate_q;
		tier_nxt = tier_q;
		dropped  = 1'b0;
		if (op == aimd_pkg::OP_LOSS) begin
			if (loss_level > cfg.loss_threshold) begin
				dropped  = 1'b1;
				rate_nxt = (half_rate < cfg.rate_floor) ? cfg.rate_floor : half_rate;
			end else if (sum_rate > {1'b0, cfg.rate_ceiling}) begin
				rate_nxt = cfg.rate_ceiling;
			end else begin
				rate_nxt = sum_rate[aimd_pkg::RATE_W-1:0];
			end
		end else begin
			priority if (up_ok) begin
				tier_nxt = tier_q + aimd_pkg::TIER_W'(1);
			end else if (dn_ok) begin
				tier_nxt = tier_q - aimd_pkg::TIER_W'(1);
			end else begin
				tier_nxt = tier_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= aimd_pkg::RESET_RATE;
			tier_q <= aimd_pkg::TIER_LOW;
		end else if (step_en) begin
			rate_q <= rate_nxt;
			tier_q <= tier_nxt;
		end
	end

	assign res.packet_rate  = rate_nxt;
	assign res.quality_tier = tier_nxt;
	assign res.tier_changed = tier_nxt != tier_q;
	assign res.rate_dropped = dropped;

endmodule

@@ sv/aimd_rate_and_tier_control_unit.sv @@
// ---------------------------------------------------------------------------
// AIMD rate and tier control unit
// Events are taken into stage one; results are registered in stage two.
// Throughput: one word per cycle while the result channel is not stalled; the
// single update of the rate and tier registers in the core sets that figure.
// Reset: asynchronous, active low; rate 500, lowest tier, registers at their
// defaults, both pipeline stages empty.
// ---------------------------------------------------------------------------
module aimd_rate_and_tier_control_unit #(
	parameter int PACKET_BYTES = aimd_pkg::PACKET_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Event channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             op,
	input  logic [aimd_pkg::LOSS_W-1:0]      loss_level,
	// Result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [aimd_pkg::RATE_W-1:0]      packet_rate,
	output logic [aimd_pkg::TIER_W-1:0]      quality_tier,
	output logic                             tier_changed,
	output logic                             rate_dropped,
	// Configuration write port
	input  logic                             cfg_we,
	input  logic [aimd_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [aimd_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

	// Stage one holds the accepted event word; stage two holds the result word.
	// The core reads the state registers while the event sits in stage one
	// and writes them as the result moves into stage two, so the next event,
	// following it into stage one, already sees the updated rate and tier.
	logic                        valid_s1;
	logic                        op_s1;
	logic [aimd_pkg::LOSS_W-1:0] loss_s1;
	logic                        valid_s2;
	aimd_pkg::result_t           res_s2;

	aimd_pkg::cfg_t    cfg;
	aimd_pkg::result_t res;
	logic              adv;

	// Stage two may be reloaded when it is empty or its word is being taken.
	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;

	aimd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	aimd_core #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (valid_s1 && adv),
		.op         (op_s1),
		.loss_level (loss_s1),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			loss_s1 <= loss_level;
		end
		if (adv && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign packet_rate  = res_s2.packet_rate;
	assign quality_tier = res_s2.quality_tier;
	assign tier_changed = res_s2.tier_changed;
	assign rate_dropped = res_s2.rate_dropped;

endmodule
